[rtl/xtea_pkg.sv]
// Shared types, constants and helper functions for the XTEA cipher core.
// Used by every module in rtl/; depends on nothing else.
package xtea_pkg;

  localparam int unsigned ROUNDS = 32;
  localparam int unsigned CELLS  = 2 * ROUNDS;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned KEY_N  = 4;

  localparam logic [WORD_W-1:0] DELTA = 32'h9E37_79B9;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [KEY_N-1:0][WORD_W-1:0] key_set_t;

  typedef enum logic [1:0] {
    KEY_W0 = 2'd0,
    KEY_W1 = 2'd1,
    KEY_W2 = 2'd2,
    KEY_W3 = 2'd3
  } key_idx_t;

  localparam word_t KEY_W0_RESET = 32'h0000_FDA5;
  localparam word_t KEY_W1_RESET = 32'h0000_D54E;
  localparam word_t KEY_W2_RESET = 32'h0000_FC00;
  localparam word_t KEY_W3_RESET = 32'h0000_B55A;

  // One block in flight.
  typedef struct packed {
    logic  cmd;
    word_t left;
    word_t right;
  } beat_t;

  // Fixed per-cell round constants.
  typedef struct packed {
    logic  odd;
    word_t sum_enc;
    word_t sum_dec;
  } cell_ctl_t;

  // Output stage status toward the top level.
  typedef struct packed {
    logic out_full;
    logic skid_full;
  } ostage_stat_t;

  function automatic word_t mix(input word_t x);
    return ((x << 4) ^ (x >> 5)) + x;
  endfunction

  // Cell c does half a round. Cell 2r updates the first word of the
  // direction's round r, cell 2r+1 the second word.
  function automatic cell_ctl_t cell_ctl(input int unsigned c);
    cell_ctl_t   ctl;
    int unsigned n;
    logic [63:0] prod_enc;
    logic [63:0] prod_dec;
    n              = (c + 1) >> 1;
    prod_enc       = 64'(DELTA) * 64'(n);
    prod_dec       = 64'(DELTA) * 64'(ROUNDS - n);
    ctl.odd        = c[0];
    ctl.sum_enc    = prod_enc[WORD_W-1:0];
    ctl.sum_dec    = prod_dec[WORD_W-1:0];
    return ctl;
  endfunction

endpackage

[rtl/xtea_cell.sv]
// One half-round cell of the XTEA pipeline with its stage register.
// Depends on xtea_pkg.
module xtea_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  xtea_pkg::cell_ctl_t ctl,
  input  xtea_pkg::key_set_t  key,
  input  logic                prev_valid,
  input  xtea_pkg::beat_t     prev_beat,
  output logic                valid,
  output xtea_pkg::beat_t     beat
);

  xtea_pkg::word_t sum;
  xtea_pkg::word_t src;
  xtea_pkg::word_t dst;
  xtea_pkg::word_t f;
  xtea_pkg::word_t upd;
  logic            upd_left;
  logic [1:0]      kidx;
  xtea_pkg::beat_t beat_next;

  // Updating the left word uses key index sum[1:0], the right word sum[12:11].
  always_comb begin
    sum      = prev_beat.cmd ? ctl.sum_dec : ctl.sum_enc;
    upd_left = ~(ctl.odd ^ prev_beat.cmd);
    kidx     = upd_left ? sum[1:0] : sum[12:11];
    src      = upd_left ? prev_beat.right : prev_beat.left;
    dst      = upd_left ? prev_beat.left : prev_beat.right;
    f        = xtea_pkg::mix(src) ^ (sum + key[kidx]);
    upd      = prev_beat.cmd ? (dst - f) : (dst + f);
    beat_next       = prev_beat;
    if (upd_left) begin
      beat_next.left = upd;
    end else begin
      beat_next.right = upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      beat <= beat_next;
    end
  end

endmodule

[rtl/xtea_ostage.sv]
// Output register plus skid register at the end of the cell chain.
// Depends on xtea_pkg.
module xtea_ostage (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   last_valid,
  input  xtea_pkg::beat_t        last_beat,
  input  logic                   stall,
  output logic                   valid,
  output xtea_pkg::beat_t        beat,
  output xtea_pkg::ostage_stat_t stat
);

  logic            skid_valid;
  xtea_pkg::beat_t skid_beat;
  logic            take;
  logic            load_last;

  assign take      = valid && !stall;
  // The chain only moves while the skid register is empty.
  assign load_last = last_valid && !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (take || !valid) begin
        valid <= skid_valid || load_last;
      end
      if (skid_valid) begin
        if (take) begin
          skid_valid <= 1'b0;
        end
      end else if (load_last && valid && !take) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take || !valid) begin
      if (skid_valid) begin
        beat <= skid_beat;
      end else begin
        beat <= last_beat;
      end
    end
    if (!skid_valid && load_last && valid && !take) begin
      skid_beat <= last_beat;
    end
  end

  assign stat.out_full  = valid;
  assign stat.skid_full = skid_valid;

endmodule

[rtl/xtea_block_cipher_core.sv]
// Top level of the pipelined XTEA cipher core: key registers, cell chain
// and output stage. Depends on xtea_pkg, xtea_cell and xtea_ostage.
//
// Usage: a block enters as one beat on the input channel (command, in_left,
// in_right) when in_valid is high and in_stall is low. Command 0 encrypts,
// command 1 decrypts. Each result leaves as one beat on the output channel
// (out_left, out_right) when out_valid is high and out_stall is low.
// The chain holds two cells per round, each doing one half-round, so with
// 32 rounds there are 64 cells. A block passes through every cell register
// and then the output register before it shows up on out_valid. One beat
// is taken every cycle while in_stall is low. When the receiver stalls, the
// chain keeps moving until the result lands in the skid register behind the
// output register; only then does the whole chain freeze and in_stall rise,
// and it drops again the cycle after the receiver takes a beat. in_stall
// comes straight from a flip-flop. Reset empties the chain and output stage
// and loads the default key. The key words are written through cfg_we,
// cfg_index and cfg_data; the user must write them only while no block is
// in flight, as the core itself does not enforce it.
module xtea_block_cipher_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  xtea_pkg::key_idx_t         cfg_index,
  input  logic [xtea_pkg::WORD_W-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       command,
  input  logic [xtea_pkg::WORD_W-1:0] in_left,
  input  logic [xtea_pkg::WORD_W-1:0] in_right,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [xtea_pkg::WORD_W-1:0] out_left,
  output logic [xtea_pkg::WORD_W-1:0] out_right
);

  xtea_pkg::key_set_t     key;
  logic                   pipe_en;
  logic                   cell_valid [xtea_pkg::CELLS+1];
  xtea_pkg::beat_t        cell_beat  [xtea_pkg::CELLS+1];
  xtea_pkg::beat_t        res_beat;
  xtea_pkg::ostage_stat_t ostat;

  // Key registers; the user must write them only while the core is idle, as the core does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      key[xtea_pkg::KEY_W0] <= xtea_pkg::KEY_W0_RESET;
      key[xtea_pkg::KEY_W1] <= xtea_pkg::KEY_W1_RESET;
      key[xtea_pkg::KEY_W2] <= xtea_pkg::KEY_W2_RESET;
      key[xtea_pkg::KEY_W3] <= xtea_pkg::KEY_W3_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        xtea_pkg::KEY_W0: key[xtea_pkg::KEY_W0] <= cfg_data;
        xtea_pkg::KEY_W1: key[xtea_pkg::KEY_W1] <= cfg_data;
        xtea_pkg::KEY_W2: key[xtea_pkg::KEY_W2] <= cfg_data;
        xtea_pkg::KEY_W3: key[xtea_pkg::KEY_W3] <= cfg_data;
        default: key <= key;
      endcase
    end
  end

  // The whole chain advances together unless the skid register is holding a beat.
  assign in_stall = ostat.skid_full;
  assign pipe_en  = !ostat.skid_full;

  assign cell_valid[0]     = in_valid;
  assign cell_beat[0].cmd   = command;
  assign cell_beat[0].left  = in_left;
  assign cell_beat[0].right = in_right;

  for (genvar i = 0; i < xtea_pkg::CELLS; i++) begin : g_cell
    localparam xtea_pkg::cell_ctl_t CTL = xtea_pkg::cell_ctl(i);
    xtea_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .en         (pipe_en),
      .ctl        (CTL),
      .key        (key),
      .prev_valid (cell_valid[i]),
      .prev_beat  (cell_beat[i]),
      .valid      (cell_valid[i+1]),
      .beat       (cell_beat[i+1])
    );
  end

  xtea_ostage u_ostage (
    .clk        (clk),
    .rst        (rst),
    .last_valid (cell_valid[xtea_pkg::CELLS]),
    .last_beat  (cell_beat[xtea_pkg::CELLS]),
    .stall      (out_stall),
    .valid      (out_valid),
    .beat       (res_beat),
    .stat       (ostat)
  );

  assign out_left  = res_beat.left;
  assign out_right = res_beat.right;

  // The skid register only fills behind a full output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    ostat.skid_full |-> ostat.out_full)
    else $error("skid register full while output register empty");

  // An accepted beat occupies the first cell on the next cycle.
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> cell_valid[1])
    else $error("accepted beat did not enter the first cell");

  // A frozen chain does not move its last beat.
  a_frozen_chain: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> $stable(cell_valid[xtea_pkg::CELLS]))
    else $error("cell chain moved while frozen");

endmodule
